@@ hdl/ospf_pkg.sv @@
// constants and codes shared by the neighbor adjacency state machine
`default_nettype none

package ospf_pkg;

	// field widths
	localparam int OpW       = 4;
	localparam int AddrW     = 32;
	localparam int StateW    = 3;
	localparam int LinkW     = 3;
	localparam int CfgIdxW   = 2;
	localparam int InDataW   = 72;
	localparam int OutDataW  = 16;

	// event codes
	localparam logic [OpW-1:0] OP_HELLO       = 4'd0;
	localparam logic [OpW-1:0] OP_TWOWAY      = 4'd1;
	localparam logic [OpW-1:0] OP_ONEWAY      = 4'd2;
	localparam logic [OpW-1:0] OP_ADJOK       = 4'd3;
	localparam logic [OpW-1:0] OP_NEGDONE     = 4'd4;
	localparam logic [OpW-1:0] OP_SEQMISMATCH = 4'd5;
	localparam logic [OpW-1:0] OP_EXCHDONE    = 4'd6;
	localparam logic [OpW-1:0] OP_LOADDONE    = 4'd7;
	localparam logic [OpW-1:0] OP_BADLSREQ    = 4'd8;
	localparam logic [OpW-1:0] OP_INACTIVITY  = 4'd9;

	// link types that always form an adjacency
	localparam logic [LinkW-1:0] LINK_P2P     = 3'd2;
	localparam logic [LinkW-1:0] LINK_P2MP    = 3'd3;
	localparam logic [LinkW-1:0] LINK_VIRTUAL = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_LINK_TYPE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_NEIGHBOR    = 2'd2;

	// action pulses of one result
	typedef struct packed {
		logic refresh_lsas;
		logic snapshot_summary;
		logic clear_lists;
		logic stop_dd_sender;
		logic start_dd_sender;
		logic reset_dd_state;
		logic start_retransmit;
		logic restart_dead_timer;
	} actions_t;

endpackage

`default_nettype wire

@@ hdl/ospf_neighbor_fsm.sv @@
// neighbor adjacency state machine with stream input, result and config ports
`default_nettype none

// One event per clock cycle while the result side does not stall; an event's result passes
// through the input register, then the result register. The rate is set by the update of
// the adjacency state and DD sender flag, which is computed from the registered event and
// written back in the same cycle the result is registered.
// The input side keeps taking events while a result waits on the output, as long as
// the input register can move on. Configuration writes are always ready; write
// link_type, own_address and neighbor_address only while no event is in flight.
module ospf_neighbor_fsm
	import ospf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// event stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// fields from bit 0: operation[3:0], desig_router[35:4], backup_router[67:36], zero pad
	input  wire logic [InDataW-1:0]  s_tdata,
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// fields from bit 0: next_state[2:0], accepted[3], restart_dead_timer[4],
	// start_retransmit[5], reset_dd_state[6], start_dd_sender[7], stop_dd_sender[8],
	// clear_lists[9], snapshot_summary[10], refresh_lsas[11], zero pad
	output logic [OutDataW-1:0]      m_tdata,
	// configuration writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [AddrW-1:0]    cfg_data
);

	typedef enum logic [StateW-1:0] {
		ST_DOWN     = 3'd0,
		ST_INIT     = 3'd1,
		ST_TWOWAY   = 3'd2,
		ST_EXSTART  = 3'd3,
		ST_EXCHANGE = 3'd4,
		ST_LOADING  = 3'd5,
		ST_FULL     = 3'd6
	} state_t;

	logic [LinkW-1:0] link_type_q;
	logic [AddrW-1:0] own_addr_q;
	logic [AddrW-1:0] neighbor_q;

	logic             valid_s1;
	logic [OpW-1:0]   op_s1;
	logic [AddrW-1:0] dr_s1;
	logic [AddrW-1:0] bdr_s1;

	state_t           state_q;
	logic             dd_active_q;

	state_t           state_d;
	logic             dd_active_d;
	logic             acc_d;
	actions_t         act_d;
	logic             want_adj;
	logic             advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= '0;
			own_addr_q  <= '0;
			neighbor_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LINK_TYPE: link_type_q <= cfg_data[LinkW-1:0];
				CFG_OWN_ADDR:  own_addr_q  <= cfg_data;
				CFG_NEIGHBOR:  neighbor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tdata[OpW-1:0];
			dr_s1  <= s_tdata[OpW+AddrW-1:OpW];
			bdr_s1 <= s_tdata[OpW+2*AddrW-1:OpW+AddrW];
		end
	end

	// adjacency decision
	assign want_adj = (link_type_q == LINK_P2P) || (link_type_q == LINK_P2MP) ||
		(link_type_q == LINK_VIRTUAL) ||
		(dr_s1 == own_addr_q) || (bdr_s1 == own_addr_q) ||
		(dr_s1 == neighbor_q) || (bdr_s1 == neighbor_q);

	// event decode and next state
	always_comb begin
		state_d     = state_q;
		dd_active_d = dd_active_q;
		acc_d       = 1'b0;
		act_d       = '0;
		unique case (op_s1)
			OP_HELLO: begin
				acc_d = 1'b1;
				act_d.restart_dead_timer = 1'b1;
				if (state_q == ST_DOWN) begin
					state_d = ST_INIT;
					act_d.start_retransmit = 1'b1;
				end
			end
			OP_TWOWAY: begin
				acc_d = 1'b1;
				if (state_q == ST_INIT) begin
					if (want_adj) begin
						state_d = ST_EXSTART;
						act_d.reset_dd_state  = 1'b1;
						act_d.start_dd_sender = 1'b1;
						dd_active_d = 1'b1;
					end else begin
						state_d = ST_TWOWAY;
					end
				end
			end
			OP_ONEWAY: begin
				if (state_q >= ST_TWOWAY) begin
					acc_d   = 1'b1;
					state_d = ST_INIT;
					act_d.clear_lists    = 1'b1;
					act_d.stop_dd_sender = 1'b1;
					dd_active_d = 1'b0;
				end else if (state_q == ST_INIT) begin
					acc_d = 1'b1;
				end
			end
			OP_ADJOK: begin
				if (state_q == ST_TWOWAY) begin
					acc_d = 1'b1;
					if (want_adj) begin
						state_d = ST_EXSTART;
						act_d.reset_dd_state  = 1'b1;
						act_d.start_dd_sender = 1'b1;
						dd_active_d = 1'b1;
					end
				end else if (state_q >= ST_EXSTART) begin
					acc_d = 1'b1;
					if (!want_adj) begin
						state_d = ST_TWOWAY;
						act_d.clear_lists    = 1'b1;
						act_d.stop_dd_sender = 1'b1;
						dd_active_d = 1'b0;
					end
				end
			end
			OP_NEGDONE: begin
				if (state_q == ST_EXSTART) begin
					acc_d   = 1'b1;
					state_d = ST_EXCHANGE;
					act_d.snapshot_summary = 1'b1;
				end
			end
			OP_SEQMISMATCH, OP_BADLSREQ: begin
				if (state_q >= ST_EXCHANGE) begin
					acc_d   = 1'b1;
					state_d = ST_EXSTART;
					act_d.clear_lists     = 1'b1;
					act_d.start_dd_sender = 1'b1;
					dd_active_d = 1'b1;
				end
			end
			OP_EXCHDONE: begin
				if (state_q == ST_EXCHANGE) begin
					acc_d   = 1'b1;
					state_d = ST_FULL;
					act_d.refresh_lsas = 1'b1;
				end
			end
			OP_LOADDONE: begin
				if (state_q == ST_LOADING) begin
					acc_d   = 1'b1;
					state_d = ST_FULL;
					act_d.refresh_lsas = 1'b1;
				end
			end
			OP_INACTIVITY: begin
				acc_d   = 1'b1;
				state_d = ST_DOWN;
				act_d.clear_lists    = 1'b1;
				act_d.stop_dd_sender = dd_active_q;
				dd_active_d = 1'b0;
			end
			default: ;
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DOWN;
			dd_active_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
		end else begin
			if (advance) begin
				state_q     <= state_d;
				dd_active_q <= dd_active_d;
				m_tdata     <= {4'b0000, act_d, acc_d, state_d};
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// the held state always matches the last registered result
	a_state_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tdata[StateW-1:0] == state_q))
		else $error("adjacency state differs from registered result");

	// the DD sender runs exactly in exstart and above
	a_dd_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		dd_active_q == (state_q >= ST_EXSTART))
		else $error("dd sender flag out of step with adjacency state");

	// a result never both starts and stops the DD sender
	a_dd_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[7] && m_tdata[8]))
		else $error("dd sender started and stopped by one event");

	// an LSA refresh only comes with reaching full
	a_refresh_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[11]) |-> (m_tdata[StateW-1:0] == ST_FULL))
		else $error("lsa refresh without full state");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the neighbor adjacency state machine
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import ospf_pkg::*;

	// neighbor states as carried in next_state
	typedef enum logic [StateW-1:0] {
		ST_DOWN, ST_INIT, ST_TWOWAY, ST_EXSTART, ST_EXCHANGE, ST_LOADING, ST_FULL
	} adj_state_t;

	// result layout, from bit 0: next_state, accepted, action pulses, zero pad
	typedef struct packed {
		logic [3:0]        pad;
		actions_t          act;
		logic              accepted;
		logic [StateW-1:0] next_state;
	} result_t;

	// link types and event codes not named in the package
	localparam logic [LinkW-1:0] LINK_BCAST    = 3'd0;
	localparam logic [LinkW-1:0] LINK_NBMA     = 3'd1;
	localparam logic [LinkW-1:0] LINK_UNDEF_LO = 3'd5;
	localparam logic [LinkW-1:0] LINK_UNDEF_HI = 3'd7;
	localparam logic [OpW-1:0]   OP_UNUSED_LO  = 4'd10;
	localparam logic [OpW-1:0]   OP_UNUSED_HI  = 4'd15;

	localparam logic [AddrW-1:0] OWN_A = 32'h0A00_0001;
	localparam logic [AddrW-1:0] NBR_A = 32'h0A00_0002;
	localparam logic [AddrW-1:0] ONES  = 32'hFFFF_FFFF;

	localparam int EVENTS_PER_SETTING = 169;
	localparam int STALL_LIMIT        = 2000;

	// tracks neighbor state, predicts each result and checks the block's output
	class adjacency_scoreboard;
		logic [LinkW-1:0] cfg_link;
		logic [AddrW-1:0] cfg_own;
		logic [AddrW-1:0] cfg_nbr;
		adj_state_t       nbr_state;
		logic             dd_active;
		result_t          expected_q[$];
		int               errors;
		int               results_seen;

		function new();
			cfg_link     = LINK_BCAST;
			cfg_own      = '0;
			cfg_nbr      = '0;
			nbr_state    = ST_DOWN;
			dd_active    = 1'b0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
			case (idx)
				CFG_LINK_TYPE: cfg_link = data[LinkW-1:0];
				CFG_OWN_ADDR:  cfg_own  = data;
				CFG_NEIGHBOR:  cfg_nbr  = data;
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch @%0t result %0d: %s", $realtime, results_seen, msg);
		endtask

		// accepted event: advance the neighbor state and queue the expected result
		function void note_event(logic [OpW-1:0] op, logic [AddrW-1:0] dr,
				logic [AddrW-1:0] bdr);
			result_t r;
			logic    want;
			r    = '0;
			want = (cfg_link inside {LINK_P2P, LINK_P2MP, LINK_VIRTUAL}) ||
				dr == cfg_own || bdr == cfg_own || dr == cfg_nbr || bdr == cfg_nbr;
			case (op)
				OP_HELLO: begin
					r.accepted = 1'b1;
					r.act.restart_dead_timer = 1'b1;
					if (nbr_state == ST_DOWN) begin
						nbr_state = ST_INIT;
						r.act.start_retransmit = 1'b1;
					end
				end
				OP_TWOWAY: begin
					r.accepted = 1'b1;
					if (nbr_state == ST_INIT) begin
						if (want) begin
							nbr_state = ST_EXSTART;
							r.act.reset_dd_state  = 1'b1;
							r.act.start_dd_sender = 1'b1;
							dd_active = 1'b1;
						end else begin
							nbr_state = ST_TWOWAY;
						end
					end
				end
				OP_ONEWAY: begin
					if (nbr_state >= ST_TWOWAY) begin
						r.accepted = 1'b1;
						nbr_state = ST_INIT;
						r.act.clear_lists    = 1'b1;
						r.act.stop_dd_sender = 1'b1;
						dd_active = 1'b0;
					end else if (nbr_state == ST_INIT) begin
						r.accepted = 1'b1;
					end
				end
				OP_ADJOK: begin
					if (nbr_state == ST_TWOWAY) begin
						r.accepted = 1'b1;
						if (want) begin
							nbr_state = ST_EXSTART;
							r.act.reset_dd_state  = 1'b1;
							r.act.start_dd_sender = 1'b1;
							dd_active = 1'b1;
						end
					end else if (nbr_state >= ST_EXSTART) begin
						r.accepted = 1'b1;
						if (!want) begin
							nbr_state = ST_TWOWAY;
							r.act.clear_lists    = 1'b1;
							r.act.stop_dd_sender = 1'b1;
							dd_active = 1'b0;
						end
					end
				end
				OP_NEGDONE: begin
					if (nbr_state == ST_EXSTART) begin
						r.accepted = 1'b1;
						nbr_state = ST_EXCHANGE;
						r.act.snapshot_summary = 1'b1;
					end
				end
				OP_SEQMISMATCH, OP_BADLSREQ: begin
					// restart the exchange without touching the DD sequence
					if (nbr_state >= ST_EXCHANGE) begin
						r.accepted = 1'b1;
						nbr_state = ST_EXSTART;
						r.act.clear_lists     = 1'b1;
						r.act.start_dd_sender = 1'b1;
						dd_active = 1'b1;
					end
				end
				OP_EXCHDONE: begin
					if (nbr_state == ST_EXCHANGE) begin
						r.accepted = 1'b1;
						nbr_state = ST_FULL;
						r.act.refresh_lsas = 1'b1;
					end
				end
				OP_LOADDONE: begin
					if (nbr_state == ST_LOADING) begin
						r.accepted = 1'b1;
						nbr_state = ST_FULL;
						r.act.refresh_lsas = 1'b1;
					end
				end
				OP_INACTIVITY: begin
					r.accepted = 1'b1;
					nbr_state = ST_DOWN;
					r.act.clear_lists    = 1'b1;
					r.act.stop_dd_sender = dd_active;
					dd_active = 1'b0;
				end
				default: ;
			endcase
			r.next_state = nbr_state;
			expected_q.insert(expected_q.size(), r);
		endfunction

		// accepted result: compare field by field with the oldest expectation
		task check_result(logic [OutDataW-1:0] data);
			result_t got;
			result_t exp;
			string   act_names[8];
			act_names = '{"restart_dead_timer", "start_retransmit", "reset_dd_state",
				"start_dd_sender", "stop_dd_sender", "clear_lists", "snapshot_summary",
				"refresh_lsas"};
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with nothing expected", data));
				return;
			end
			got = data;
			exp = expected_q.pop_front();
			if (got.next_state !== exp.next_state)
				report($sformatf("next_state %0d, expected %0d", got.next_state,
					exp.next_state));
			if (got.accepted !== exp.accepted)
				report($sformatf("accepted %b, expected %b", got.accepted, exp.accepted));
			for (int i = 0; i < 8; i++)
				if (got.act[i] !== exp.act[i])
					report($sformatf("%s %b, expected %b", act_names[i], got.act[i],
						exp.act[i]));
			if (got.pad !== '0)
				report($sformatf("pad bits %b, expected zero", got.pad));
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	wire logic          s_tready;
	logic [InDataW-1:0] s_tdata   = '0;
	wire logic          m_tvalid;
	logic               m_tready  = 1'b0;
	wire logic [OutDataW-1:0] m_tdata;
	logic               cfg_valid = 1'b0;
	wire logic          cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [AddrW-1:0]   cfg_data  = '0;

	adjacency_scoreboard sb = new();
	logic burst = 1'b0;
	int   idle_cycles = 0;

	ospf_neighbor_fsm i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result side: random stalls, none while in a burst
	initial begin
		int stall;
		forever begin
			stall = burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// one register transfer; leaves cfg_valid high for a following write
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// full register setting; upper link type bits carry noise
	task automatic write_config(logic [LinkW-1:0] link, logic [AddrW-1:0] own,
			logic [AddrW-1:0] nbr);
		write_reg(CFG_LINK_TYPE, ($urandom() & ~32'h7) | link);
		write_reg(CFG_OWN_ADDR, own);
		write_reg(CFG_NEIGHBOR, nbr);
		cfg_valid <= 1'b0;
	endtask

	// one event transfer after a random gap, none while in a burst
	task automatic send_event(logic [OpW-1:0] op, logic [AddrW-1:0] dr,
			logic [AddrW-1:0] bdr);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, bdr, dr, op};
		do @(posedge clk); while (!s_tready);
		sb.note_event(op, dr, bdr);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// DR/BDR value biased toward the configured addresses
	function automatic logic [AddrW-1:0] pick_addr();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll <= 2) return sb.cfg_own;
		if (roll <= 4) return sb.cfg_nbr;
		if (roll == 8) return '0;
		if (roll == 9) return ONES;
		return $urandom();
	endfunction

	// event that mostly moves the adjacency forward; exchange sometimes restarts, full gets a random event
	function automatic logic [OpW-1:0] progress_op();
		case (sb.nbr_state)
			ST_DOWN:     return OP_HELLO;
			ST_INIT:     return OP_TWOWAY;
			ST_TWOWAY:   return OP_ADJOK;
			ST_EXSTART:  return OP_NEGDONE;
			ST_EXCHANGE: begin
				case ($urandom_range(0, 5))
					0:       return OP_SEQMISMATCH;
					1:       return OP_BADLSREQ;
					default: return OP_EXCHDONE;
				endcase
			end
			default: begin
				case ($urandom_range(0, 5))
					0:       return OP_ADJOK;
					1:       return OP_ONEWAY;
					2:       return OP_SEQMISMATCH;
					3:       return OP_BADLSREQ;
					4:       return OP_HELLO;
					default: return OP_INACTIVITY;
				endcase
			end
		endcase
	endfunction

	// mostly well-formed progress, some noise and unused codes
	task automatic random_events(int count);
		int              roll;
		logic [OpW-1:0]  op;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 65)
				op = progress_op();
			else if (roll < 95)
				op = OpW'($urandom_range(OP_INACTIVITY, OP_HELLO));
			else
				op = OpW'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
			send_event(op, pick_addr(), pick_addr());
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// broadcast link, directed walk through every event and every state but loading
		write_config(LINK_BCAST, OWN_A, NBR_A);
		send_event(OP_ONEWAY, '0, '0);          // rejected in down
		send_event(OP_ADJOK, OWN_A, NBR_A);     // rejected in down
		send_event(OP_INACTIVITY, '0, '0);      // sender idle, no stop pulse
		send_event(OP_HELLO, ONES, ONES);       // down to init
		send_event(OP_HELLO, '0, '0);           // init stays, timer only
		send_event(OP_ONEWAY, '0, '0);          // init accepted, no change
		send_event(OP_ADJOK, OWN_A, OWN_A);     // rejected in init
		send_event(OP_TWOWAY, ONES, ONES);      // no adjacency wanted: twoway
		send_event(OP_NEGDONE, '0, '0);         // rejected in twoway
		send_event(OP_ADJOK, ONES, '0);         // still not wanted, stay
		send_event(OP_ADJOK, '0, NBR_A);        // wanted through BDR: exstart
		send_event(OP_SEQMISMATCH, '0, '0);     // rejected in exstart
		send_event(OP_NEGDONE, '0, '0);         // exchange
		send_event(OP_BADLSREQ, '0, '0);        // back to exstart
		send_event(OP_NEGDONE, '0, '0);
		send_event(OP_SEQMISMATCH, '0, '0);
		send_event(OP_NEGDONE, '0, '0);
		send_event(OP_EXCHDONE, '0, '0);        // exchange straight to full
		send_event(OP_LOADDONE, '0, '0);        // rejected outside loading
		send_event(OP_ADJOK, OWN_A, ONES);      // still wanted through DR
		send_event(OP_ADJOK, '0, ONES);         // lost: back to twoway
		send_event(OP_ONEWAY, ONES, ONES);      // twoway to init
		send_event(OP_TWOWAY, NBR_A, '0);       // wanted through DR: exstart
		send_event(OP_UNUSED_LO, OWN_A, NBR_A); // ignored code
		send_event(OP_UNUSED_HI, ONES, ONES);   // ignored code
		send_event(OP_INACTIVITY, ONES, '0);    // sender active, stop pulse
		random_events(EVENTS_PER_SETTING - 26);
		drain();

		// other link types and address extremes
		write_config(LINK_P2P, '0, ONES);
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_P2MP, ONES, '0);
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_VIRTUAL, $urandom(), $urandom());
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_NBMA, $urandom(), $urandom());
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_UNDEF_HI, ONES, ONES);
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_UNDEF_LO, $urandom(), $urandom());
		random_events(EVENTS_PER_SETTING);
		drain();
		write_config(LINK_BCAST, '0, '0);
		random_events(EVENTS_PER_SETTING);
		drain();

		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ ospf_neighbor_fsm.f @@
hdl/ospf_pkg.sv
hdl/ospf_neighbor_fsm.sv
test/tb_top.sv
